// ----- rtl/core/kct_pkg.sv -----
// Shared types and constants for the keyed count table.
`default_nettype none

package kct_pkg;

    localparam int OP_W         = 2;
    localparam int KEY_IN_W     = 16;
    localparam int AMT_W        = 16;
    localparam int CNT_OUT_W    = 16;
    localparam int ST_W         = 2;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        logic             amt_zero;
        logic [AMT_W-1:0] amount;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/kct_if.sv -----
// Request and response channel interfaces of the keyed count table.
`default_nettype none

interface kct_req_if;
    import kct_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [KEY_IN_W-1:0] key;
    logic [AMT_W-1:0]    amount;

    modport source (output valid, output op, output key, output amount, input ready);
    modport sink   (input valid, input op, input key, input amount, output ready);
endinterface

interface kct_rsp_if;
    import kct_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CNT_OUT_W-1:0] count;
    logic                 present;
    logic [ST_W-1:0]      status;

    modport source (output valid, output count, output present, output status, input ready);
    modport sink   (input valid, input count, input present, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/kct_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module kct_front #(
    parameter int KEY_BITS = kct_pkg::KEY_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    kct_req_if.sink             i_req,
    input  wire logic           i_init_busy,
    output logic                o_cmd_valid,
    output kct_pkg::t_cmd       o_cmd,
    output logic [KEY_BITS-1:0] o_key,
    input  wire logic           i_cmd_ready
);
    import kct_pkg::*;

    localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int FILL_W = $clog2(QDEPTH + 1);

    t_cmd                r_cmd_q [QDEPTH];
    logic [KEY_BITS-1:0] r_key_q [QDEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]   r_fill, n_fill;

    t_cmd                new_cmd;
    logic [KEY_BITS-1:0] new_key;
    logic                push, pop;

    assign i_req.ready = (r_fill != FILL_W'(QDEPTH)) && !i_init_busy;
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_fill != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_cmd_q[r_rd_ptr];
    assign o_key       = r_key_q[r_rd_ptr];

    always_comb begin
        new_cmd.op       = t_op'(i_req.op);
        new_cmd.amount   = i_req.amount;
        new_cmd.amt_zero = (i_req.amount == '0);
        new_key          = KEY_BITS'(i_req.key);

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd_q[r_wr_ptr] <= new_cmd;
            r_key_q[r_wr_ptr] <= new_key;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/kct_back.sv -----
// Back end: sequential key search over the table memory, update and result register.
`default_nettype none

module kct_back #(
    parameter int ENTRIES    = kct_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = kct_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = kct_pkg::COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_valid,
    input  wire kct_pkg::t_cmd       i_cmd,
    input  wire logic [KEY_BITS-1:0] i_key,
    output logic                     o_cmd_ready,
    output logic                     o_init_busy,
    kct_rsp_if.source                o_rsp
);
    import kct_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SUM_W = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_CLR,
        S_EXEC
    } t_state;

    localparam logic [SUM_W-1:0] CMAX = SUM_W'({COUNT_BITS{1'b1}});
    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;
    logic   r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    t_cmd                  r_cmd, n_cmd;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    logic                  r_has_free, n_has_free;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic                  r_out_valid, n_out_valid;
    logic [CNT_OUT_W-1:0]  r_out_count, n_out_count;
    logic                  r_out_present, n_out_present;
    t_status               r_out_status, n_out_status;

    logic             rd_en;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_entry           mem_wd;

    logic [SUM_W-1:0] amt_w, cnt_w, sum_w, res_w;
    t_status          res_st;

    assign rd_en         = (r_state == S_SCAN);
    assign o_cmd_ready   = (r_state == S_IDLE);
    assign o_init_busy   = (r_state == S_INIT);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.count   = r_out_count;
    assign o_rsp.present = r_out_present;
    assign o_rsp.status  = r_out_status;

    assign amt_w = SUM_W'(r_cmd.amount);
    assign cnt_w = SUM_W'(r_hit_cnt);
    assign sum_w = cnt_w + amt_w;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_cmd         = r_cmd;
        n_key         = r_key;
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_hit_cnt     = r_hit_cnt;
        n_has_free    = r_has_free;
        n_free_idx    = r_free_idx;
        n_out_valid   = r_out_valid;
        n_out_count   = r_out_count;
        n_out_present = r_out_present;
        n_out_status  = r_out_status;
        mem_we        = 1'b0;
        mem_wa        = r_idx;
        mem_wd        = '0;
        res_w         = '0;
        res_st        = ST_OK;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        // returning search data
        if (r_rd_vld) begin
            if (r_rd_data.valid && (r_rd_data.key == r_key)) begin
                n_hit     = 1'b1;
                n_hit_idx = r_rd_idx;
                n_hit_cnt = r_rd_data.count;
            end
            if (!r_rd_data.valid && !r_has_free) begin
                n_has_free = 1'b1;
                n_free_idx = r_rd_idx;
            end
        end

        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd      = i_cmd;
                    n_key      = i_key;
                    n_idx      = '0;
                    n_hit      = 1'b0;
                    n_has_free = 1'b0;
                    n_state    = (i_cmd.op == OP_CLEAR) ? S_CLR : S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_EXEC;
            end
            S_CLR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    case (r_cmd.op)
                        OP_QUERY: begin
                            res_w = r_hit ? cnt_w : '0;
                        end
                        OP_ADD: begin
                            if (r_hit) begin
                                res_w = sum_w;
                                if (sum_w > CMAX) begin
                                    res_w  = CMAX;
                                    res_st = ST_SATURATED;
                                end
                                mem_we = 1'b1;
                                mem_wa = r_hit_idx;
                            end else if (!r_cmd.amt_zero) begin
                                if (r_has_free) begin
                                    res_w = amt_w;
                                    if (amt_w > CMAX) begin
                                        res_w  = CMAX;
                                        res_st = ST_SATURATED;
                                    end
                                    mem_we = 1'b1;
                                    mem_wa = r_free_idx;
                                end else begin
                                    res_st = ST_FULL;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                if (cnt_w >= amt_w) begin
                                    res_w  = cnt_w - amt_w;
                                    mem_we = 1'b1;
                                    mem_wa = r_hit_idx;
                                end else begin
                                    res_w  = cnt_w;
                                    res_st = ST_REFUSED;
                                end
                            end else begin
                                res_st = ST_REFUSED;
                            end
                        end
                        default: begin
                            res_w = '0;
                        end
                    endcase
                    mem_wd.valid  = (res_w != '0);
                    mem_wd.key    = r_key;
                    mem_wd.count  = res_w[COUNT_BITS-1:0];
                    n_out_valid   = 1'b1;
                    n_out_count   = res_w[CNT_OUT_W-1:0];
                    n_out_present = (res_w != '0);
                    n_out_status  = res_st;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx      <= r_idx;
        r_cmd         <= n_cmd;
        r_key         <= n_key;
        r_hit_idx     <= n_hit_idx;
        r_hit_cnt     <= n_hit_cnt;
        r_free_idx    <= n_free_idx;
        r_out_count   <= n_out_count;
        r_out_present <= n_out_present;
        r_out_status  <= n_out_status;
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_has_free  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rd_vld    <= rd_en;
            r_hit       <= n_hit;
            r_has_free  <= n_has_free;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/keyed_count_table_unit.sv -----
// Keyed count table top level: request queue front end and table search back end.
// A queued request is taken by the back end, which scans the table one entry a cycle (a clear
// writes each entry in turn instead), then updates the entry and registers the response; a
// response left waiting holds the back end in its last step, with one request worked at a time.
// The front queue holds two requests, so the request side keeps accepting while one is worked.
// Reset: synchronous, active low; a sweep over all ENTRIES entries then empties the table, with
// request ready held low until it ends.
`default_nettype none

module keyed_count_table_unit #(
    parameter int ENTRIES    = kct_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = kct_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = kct_pkg::COUNT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kct_req_if.sink   i_req,
    kct_rsp_if.source o_rsp
);
    import kct_pkg::*;

    logic                cmd_valid;
    logic                cmd_ready;
    t_cmd                cmd;
    logic [KEY_BITS-1:0] cmd_key;
    logic                init_busy;

    kct_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_init_busy (init_busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .o_key       (cmd_key),
        .i_cmd_ready (cmd_ready)
    );

    kct_back #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .i_key       (cmd_key),
        .o_cmd_ready (cmd_ready),
        .o_init_busy (init_busy),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the keyed count table: queued requests, shadow table, random stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kct_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int TBL_N      = ENTRIES_DEF;
    localparam int KEY_W      = KEY_BITS_DEF;
    localparam int CNT_W      = COUNT_BITS_DEF;
    localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 64'd1;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct {
        t_op                 op;
        logic [KEY_IN_W-1:0] key;
        logic [AMT_W-1:0]    amount;
        bit                  hold;   // wait for every outstanding result first
    } t_table_req;

    typedef struct {
        logic [CNT_OUT_W-1:0] count;
        logic                 present;
        t_status              status;
    } t_count_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kct_req_if req_ch ();
    kct_rsp_if rsp_ch ();

    keyed_count_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow of the table
    logic [KEY_W-1:0] tbl_key [TBL_N];
    logic [CNT_W-1:0] tbl_cnt [TBL_N];
    bit               tbl_used [TBL_N] = '{default: 1'b0};

    t_table_req req_backlog [$];
    t_count_rsp due_counts [$];
    t_table_req cur_req;

    int n_items;
    int sent_n      = 0;
    int sent_total  = 0;
    int rsp_total   = 0;
    int errors      = 0;
    int send_gap    = 0;
    int recv_gap    = 0;
    bit send_burst  = 1'b0;
    bit recv_burst  = 1'b0;

    function automatic t_count_rsp apply_table_request(t_table_req rq);
        t_count_rsp       r;
        int               hit;
        int               vac;
        logic [KEY_W-1:0] k;
        longint unsigned  held;
        longint unsigned  sum;
        r.count   = '0;
        r.present = 1'b0;
        r.status  = ST_OK;
        k    = KEY_W'(rq.key);
        hit  = -1;
        vac  = -1;
        held = 0;
        for (int i = TBL_N - 1; i >= 0; i--) begin
            if (tbl_used[i] && tbl_key[i] == k) hit = i;
            if (!tbl_used[i]) vac = i;
        end
        case (rq.op)
            OP_QUERY: begin
                if (hit >= 0) held = tbl_cnt[hit];
            end
            OP_ADD: begin
                if (hit >= 0) begin
                    sum = tbl_cnt[hit];
                    sum += rq.amount;
                    if (sum > CNT_MAX) begin
                        sum      = CNT_MAX;
                        r.status = ST_SATURATED;
                    end
                    tbl_cnt[hit] = CNT_W'(sum);
                    held         = sum;
                end else if (rq.amount != 0) begin
                    if (vac >= 0) begin
                        sum = rq.amount;
                        if (sum > CNT_MAX) begin
                            sum      = CNT_MAX;
                            r.status = ST_SATURATED;
                        end
                        tbl_used[vac] = 1'b1;
                        tbl_key[vac]  = k;
                        tbl_cnt[vac]  = CNT_W'(sum);
                        held          = sum;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            OP_REMOVE: begin
                if (hit < 0) begin
                    r.status = ST_REFUSED;
                end else begin
                    held = tbl_cnt[hit];
                    if (held >= rq.amount) begin
                        held -= rq.amount;
                        tbl_cnt[hit] = CNT_W'(held);
                        if (held == 0) tbl_used[hit] = 1'b0;
                    end else begin
                        r.status = ST_REFUSED;
                    end
                end
            end
            default: begin
                tbl_used = '{default: 1'b0};
            end
        endcase
        r.count   = CNT_OUT_W'(held);
        r.present = (held != 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got_v, longint unsigned exp_v);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got_v, exp_v);
        errors++;
    endtask

    task automatic queue_request(t_op op, logic [KEY_IN_W-1:0] key, logic [AMT_W-1:0] amount,
                                 bit hold);
        t_table_req rq;
        rq.op     = op;
        rq.key    = key;
        rq.amount = amount;
        rq.hold   = hold;
        req_backlog = {req_backlog, rq};
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                due_counts = {due_counts, apply_table_request(cur_req)};
                sent_n++;
                sent_total <= sent_n;
                if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 5);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (req_backlog.size() > 0 &&
                             (!req_backlog[0].hold || sent_n == rsp_total)) begin
                    cur_req = req_backlog.pop_front();
                    req_ch.op     <= cur_req.op;
                    req_ch.key    <= cur_req.key;
                    req_ch.amount <= cur_req.amount;
                    req_ch.valid  <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (due_counts.size() == 0) begin
                    report_mismatch("unexpected result, count", rsp_ch.count, 0);
                end else begin
                    if (rsp_ch.count !== due_counts[0].count)
                        report_mismatch("count", rsp_ch.count, due_counts[0].count);
                    if (rsp_ch.present !== due_counts[0].present)
                        report_mismatch("present", rsp_ch.present, due_counts[0].present);
                    if (rsp_ch.status !== due_counts[0].status)
                        report_mismatch("status", rsp_ch.status, due_counts[0].status);
                    void'(due_counts.pop_front());
                end
                rsp_total <= rsp_total + 1;
                if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 5);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [KEY_IN_W-1:0] key_pool [24];
        int                  pool_n;
        int                  add_pct;
        int                  pick;
        bit                  hold;
        t_op                 op;
        logic [KEY_IN_W-1:0] key;
        logic [AMT_W-1:0]    amount;

        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.op     = OP_QUERY;
        req_ch.key    = '0;
        req_ch.amount = '0;
        rsp_ch.ready  = 1'b0;

        // directed corners
        queue_request(OP_QUERY,  16'h0000, 16'h0000, 1'b0);
        queue_request(OP_REMOVE, 16'h0000, 16'h0000, 1'b0);
        queue_request(OP_ADD,    16'h1234, 16'h0000, 1'b0);
        queue_request(OP_QUERY,  16'h1234, 16'hFFFF, 1'b0);
        queue_request(OP_ADD,    16'hFFFF, 16'hFFFF, 1'b0);
        queue_request(OP_ADD,    16'hFFFF, 16'h0001, 1'b0);
        queue_request(OP_QUERY,  16'hFFFF, 16'h0000, 1'b0);
        queue_request(OP_REMOVE, 16'hFFFF, 16'h0000, 1'b0);
        queue_request(OP_REMOVE, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_request(OP_QUERY,  16'hFFFF, 16'h0000, 1'b0);
        queue_request(OP_ADD,    16'h0000, 16'h000A, 1'b0);
        queue_request(OP_REMOVE, 16'h0000, 16'h000B, 1'b0);
        queue_request(OP_ADD,    16'h8001, 16'hFFFE, 1'b0);
        queue_request(OP_ADD,    16'h8001, 16'h0005, 1'b0);
        queue_request(OP_CLEAR,  16'hA5A5, 16'h5A5A, 1'b1);
        queue_request(OP_QUERY,  16'h0000, 16'h0000, 1'b0);
        queue_request(OP_QUERY,  16'h8001, 16'h0000, 1'b0);
        queue_request(OP_REMOVE, 16'h8001, 16'h0000, 1'b0);

        // random phases over small key pools; pools above the table size drive it full
        while (req_backlog.size() < 18 + RANDOM_ITEMS) begin
            pool_n  = $urandom_range(1, 24);
            add_pct = $urandom_range(30, 75);
            for (int i = 0; i < pool_n; i++) begin
                case ($urandom_range(0, 7))
                    0:       key_pool[i] = 16'h0000;
                    1:       key_pool[i] = 16'hFFFF;
                    default: key_pool[i] = KEY_IN_W'($urandom);
                endcase
            end
            hold = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(10, 60)) begin
                pick = $urandom_range(0, 99);
                if (pick < add_pct)           op = OP_ADD;
                else if (pick < add_pct + 20) op = OP_REMOVE;
                else if (pick < 98)           op = OP_QUERY;
                else                          op = OP_CLEAR;
                key = key_pool[$urandom_range(0, pool_n - 1)];
                case ($urandom_range(0, 9))
                    0:       amount = '0;
                    1:       amount = AMT_W'(16'hFFFF - $urandom_range(0, 15));
                    2:       amount = AMT_W'($urandom);
                    default: amount = AMT_W'($urandom_range(1, 16));
                endcase
                // noise: stray keys and ops
                if ($urandom_range(0, 15) == 0) begin
                    op  = t_op'($urandom_range(0, 3));
                    key = KEY_IN_W'($urandom);
                end
                queue_request(op, key, amount, hold);
                hold = 1'b0;
            end
        end
        n_items = req_backlog.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (sent_total != n_items || rsp_total < n_items);
        repeat (TBL_N + 12) @(posedge i_clk);
        #1;
        if (due_counts.size() != 0)
            report_mismatch("results missing", 0, due_counts.size());
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/kct_pkg.sv
rtl/core/kct_if.sv
rtl/core/kct_front.sv
rtl/core/kct_back.sv
rtl/core/keyed_count_table_unit.sv
bench/testbench.sv
